// ===== rtl/matp_pkg.sv =====
// Shared types and constants for the medial-axis thinning pass.
// Holds the request codes, field widths and the controller/datapath command and status structs.
// No dependencies.
package matp_pkg;

  // Default store dimensions, handed to the top-level parameters.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Fixed field widths.
  localparam int ROW_W      = 8;
  localparam int COL_W      = 8;
  localparam int CFG_W      = 9;
  localparam int CODE_W     = 9;
  localparam int KEEP_DEPTH = 512;
  localparam int S_TDATA_W  = 32;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 16;
  localparam int M_TUSER_W  = 1;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Request kinds carried in tuser.
  typedef enum logic [1:0] {
    REQ_LOAD_PIXEL = 2'd0,
    REQ_LOAD_TABLE = 2'd1,
    REQ_THIN       = 2'd2,
    REQ_READ       = 2'd3
  } req_t;

  // Row of the 3x3 window relative to the centre pixel.
  typedef enum logic [1:0] {
    ROW_ABOVE  = 2'd0,
    ROW_CENTRE = 2'd1,
    ROW_BELOW  = 2'd2
  } row_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch;
    logic     init_res;
    row_sel_t row_sel;
    logic     cap_en;
    row_sel_t cap_row;
    logic     cap_read;
    logic     pix_we;
    logic     wb_we;
    logic     keep_we;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req;
    logic pos_err;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/matp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the pixel store banks and the keep table. No dependencies.
module matp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in program order, read data registered; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/matp_ctrl.sv =====
// Controller state machine for the medial-axis thinning pass.
// Sequences loads, reads and the three-row window fetch; depends on matp_pkg.
module matp_ctrl
  import matp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_ROW0   = 9'b000000100,
    S_ROW1   = 9'b000001000,
    S_ROW2   = 9'b000010000,
    S_LOOK   = 9'b000100000,
    S_WB     = 9'b001000000,
    S_RDCAP  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.row_sel = ROW_CENTRE;
    cmd.cap_row = ROW_CENTRE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.init_res = 1'b1;
        if (stat.req == REQ_LOAD_TABLE) begin
          cmd.keep_we = 1'b1;
          state_next  = S_DONE;
        end else if (stat.pos_err) begin
          state_next = S_DONE;
        end else begin
          case (stat.req)
            REQ_LOAD_PIXEL: begin
              cmd.pix_we = 1'b1;
              state_next = S_DONE;
            end
            REQ_READ: begin
              state_next = S_RDCAP;
            end
            REQ_THIN: begin
              cmd.row_sel = ROW_ABOVE;
              state_next  = S_ROW0;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      // Capture each row in the state after its read is issued.
      S_ROW0: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_row = ROW_ABOVE;
        cmd.row_sel = ROW_CENTRE;
        state_next  = S_ROW1;
      end
      S_ROW1: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_row = ROW_CENTRE;
        cmd.row_sel = ROW_BELOW;
        state_next  = S_ROW2;
      end
      S_ROW2: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_row = ROW_BELOW;
        state_next  = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb_we  = 1'b1;
        state_next = S_DONE;
      end
      S_RDCAP: begin
        cmd.cap_read = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/matp_dp.sv =====
// Datapath for the medial-axis thinning pass: config registers, item latch,
// three column-interleaved pixel banks, keep table and output register.
// Depends on matp_pkg and matp_ram.
module matp_dp
  import matp_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [S_TDATA_W-1:0] in_data,
  input  logic [S_TUSER_W-1:0] in_user,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [M_TDATA_W-1:0] out_data,
  output logic [M_TUSER_W-1:0] out_user
);

  // Columns are spread over three banks by column mod 3, so one read per
  // bank fetches a whole three-pixel row of the window.
  localparam int BANK_COLS  = (MAX_WIDTH + 2) / 3;
  localparam int BANK_DEPTH = BANK_COLS * MAX_HEIGHT;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int KEEP_AW    = $clog2(KEEP_DEPTH);
  localparam int DIV3_MUL   = 171;
  localparam int DIV3_SHIFT = 9;

  logic [CFG_W-1:0] image_width, image_height;
  logic [CFG_W-1:0] eff_w, eff_h;

  req_t             it_req;
  logic [ROW_W-1:0] it_row;
  logic [COL_W-1:0] it_col;
  logic [COL_W-1:0] it_q;
  logic [1:0]       it_m;
  logic             it_pv;
  logic [KEEP_AW-1:0] it_ti;
  logic             it_tb;

  logic [15:0]      q_prod;
  logic [COL_W-1:0] col_q_in;
  logic [1:0]       col_m_in;

  logic up_ok, dn_ok, lf_ok, rt_ok, pos_err;
  logic [1:0] lb, rb;
  logic [ROW_W-1:0] row_addr;

  logic [COL_W-1:0]   bank_col   [3];
  logic [BANK_AW-1:0] bank_addr  [3];
  logic               bank_we    [3];
  logic               bank_wdata [3];
  logic               bank_q     [3];

  logic d_left, d_centre, d_right;
  logic up_l, up_c, up_r, mid_l, mid_r, dn_l, dn_c, dn_r;
  logic [CODE_W-1:0] code;
  logic              keep_q;

  logic              res_pix, res_err;
  logic [CODE_W-1:0] res_code;
  logic              o_pix, o_err;
  logic [CODE_W-1:0] o_code;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(256);
      image_height <= CFG_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Register values above the store size saturate.
  assign eff_w = (32'(image_width) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : image_width;
  assign eff_h = (32'(image_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : image_height;

  // Column divided by three through a reciprocal multiply; exact for 8-bit columns.
  assign q_prod   = 16'(in_data[ROW_W +: COL_W]) * 16'(DIV3_MUL);
  assign col_q_in = COL_W'(q_prod >> DIV3_SHIFT);
  assign col_m_in = 2'(in_data[ROW_W +: COL_W] - COL_W'(32'(col_q_in) * 3));

  // Item latch.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_req <= req_t'(in_user);
      it_row <= in_data[0 +: ROW_W];
      it_col <= in_data[ROW_W +: COL_W];
      it_q   <= col_q_in;
      it_m   <= col_m_in;
      it_pv  <= in_data[ROW_W + COL_W];
      it_ti  <= in_data[ROW_W + COL_W + 1 +: KEEP_AW];
      it_tb  <= in_data[ROW_W + COL_W + 1 + KEEP_AW];
    end
  end

  // Position checks against the configured image.
  assign pos_err = !(({1'b0, it_row} < eff_h) && ({1'b0, it_col} < eff_w));
  assign up_ok   = (it_row != '0);
  assign lf_ok   = (it_col != '0);
  assign dn_ok   = ({1'b0, it_row} + CFG_W'(1)) < eff_h;
  assign rt_ok   = ({1'b0, it_col} + CFG_W'(1)) < eff_w;

  assign stat.req      = it_req;
  assign stat.pos_err  = pos_err;
  assign stat.out_free = !out_valid || out_ready;

  // Banks holding the left and right neighbour columns.
  assign lb = (it_m == 2'd0) ? 2'd2 : it_m - 2'd1;
  assign rb = (it_m == 2'd2) ? 2'd0 : it_m + 2'd1;

  // Row being addressed this cycle.
  always_comb begin
    case (cmd.row_sel)
      ROW_ABOVE: row_addr = up_ok ? it_row - ROW_W'(1) : it_row;
      ROW_BELOW: row_addr = dn_ok ? it_row + ROW_W'(1) : it_row;
      default:   row_addr = it_row;
    endcase
  end

  // Per-bank column and address; writes only ever go to the centre bank.
  always_comb begin
    for (int b = 0; b < 3; b++) begin
      if (2'(b) == it_m) begin
        bank_col[b] = it_q;
      end else if (2'(b) == rb) begin
        bank_col[b] = (it_m == 2'd2) ? it_q + COL_W'(1) : it_q;
      end else begin
        bank_col[b] = (it_m == 2'd0 && lf_ok) ? it_q - COL_W'(1) : it_q;
      end
      bank_addr[b]  = BANK_AW'(32'(row_addr) * BANK_COLS + 32'(bank_col[b]));
      bank_we[b]    = (cmd.pix_we || cmd.wb_we) && (2'(b) == it_m);
      bank_wdata[b] = cmd.wb_we ? keep_q : it_pv;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_bank
    matp_ram #(
      .WIDTH(1),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (bank_we[g]),
      .waddr(bank_addr[g]),
      .wdata(bank_wdata[g]),
      .raddr(bank_addr[g]),
      .rdata(bank_q[g])
    );
  end

  assign d_left   = bank_q[lb];
  assign d_centre = bank_q[it_m];
  assign d_right  = bank_q[rb];

  // Window capture; neighbours outside the image count as zero.
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_row)
        ROW_ABOVE: begin
          up_l <= d_left & up_ok & lf_ok;
          up_c <= d_centre & up_ok;
          up_r <= d_right & up_ok & rt_ok;
        end
        ROW_BELOW: begin
          dn_l <= d_left & dn_ok & lf_ok;
          dn_c <= d_centre & dn_ok;
          dn_r <= d_right & dn_ok & rt_ok;
        end
        default: begin
          mid_l <= d_left & lf_ok;
          mid_r <= d_right & rt_ok;
        end
      endcase
    end
  end

  // Neighbourhood code, centre always set.
  assign code = {dn_r, dn_c, dn_l, mid_r, 1'b1, mid_l, up_r, up_c, up_l};

  matp_ram #(
    .WIDTH(1),
    .DEPTH(KEEP_DEPTH)
  ) u_keep (
    .clk  (clk),
    .we   (cmd.keep_we),
    .waddr(it_ti),
    .wdata(it_tb),
    .raddr(code),
    .rdata(keep_q)
  );

  // Result being built for the current item.
  always_ff @(posedge clk) begin
    if (cmd.init_res) begin
      res_pix  <= 1'b0;
      res_code <= '0;
      res_err  <= pos_err && (it_req != REQ_LOAD_TABLE);
    end else if (cmd.cap_read) begin
      res_pix <= d_centre;
    end else if (cmd.wb_we) begin
      res_pix  <= keep_q;
      res_code <= code;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_pix  <= res_pix;
      o_code <= res_code;
      o_err  <= res_err;
    end
  end

  assign out_data = {(M_TDATA_W - CODE_W - 1)'(0), o_code, o_pix};
  assign out_user = o_err;

endmodule

// ===== rtl/medial_axis_thinning_pass.sv =====
// Top level of the medial-axis thinning pass: controller plus datapath.
// Depends on matp_pkg, matp_ctrl, matp_dp and matp_ram.
//
// Usage: items arrive on the s_axis word channel, the request kind in tuser.
// Every accepted word yields exactly one result word on m_axis. Image width
// and height are written through the cfg channel, which is always ready; write
// only while no item is in flight.
// Steps per item, from acceptance to the result:
//   table load, pixel load, out-of-range position: decode, then output load;
//   pixel read: decode, one pixel-store read, output load;
//   thin: decode, three row reads of the banked pixel store, one keep-table
//   read, one write-back, one output load.
// One item is in work at a time; the next word is taken on the cycle after a
// result is loaded into the output register, and that load waits while the
// output register is still full.
// Reset clears the controller, the output valid and the configuration
// (width and height 256); the pixel store and keep table hold whatever was
// last written and must be loaded before use.
// When m_axis stalls, the result stays in the output register and the next
// item may still be accepted and worked on; its result waits until the
// output register is free.
module medial_axis_thinning_pass
  import matp_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // Request stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // row[7:0], col[15:8], pixel_value[16], table_index[25:17], table_bit[26], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pixel_out[0], neighbourhood_code[9:1], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // position_error[0]
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  matp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  matp_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser)
  );

endmodule

// ===== rtl/matp_checker.sv =====
// Port-level checks for the medial-axis thinning pass, bound to the top level.
// Depends on matp_pkg and medial_axis_thinning_pass.
module matp_checker
  import matp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // One item at a time: after an accept the input side is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  // A position error carries no pixel and no code.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[CODE_W:0] == '0)
    else $error("error result with nonzero payload");

  // Any nonzero code has the centre weight set.
  a_code_centre: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[CODE_W:1] != '0) |-> m_axis_tdata[5])
    else $error("neighbourhood code without centre bit");

endmodule

bind medial_axis_thinning_pass matp_checker u_matp_checker (.*);
